FILE: hdl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Types and constants for the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int SLOTS      = 1024;               // power of two
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int HALF_SLOTS = SLOTS / 2;
  localparam int COUNT_W    = SLOT_W + 1;
  localparam int KEY_W      = 64;
  localparam int PAY_W      = 32;

  // multiplicative fold: only bits below 32 + SLOT_W of the product matter
  localparam int HASH_W      = 32 + SLOT_W;
  localparam int CHUNK_W     = 16;
  localparam int HASH_CHUNKS = (HASH_W + CHUNK_W - 1) / CHUNK_W;
  localparam int HCNT_W      = $clog2(HASH_CHUNKS);
  localparam logic [63:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;

  localparam int S_TDATA_W = ((KEY_W + PAY_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((1 + PAY_W + 1 + 7) / 8) * 8;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [PAY_W-1:0]  payload;
  } entry_t;

endpackage

FILE: hdl/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressed hash table of 64-bit keys with linear probing.
// The hash folds the key 16 bits at a time, then the probe reads one slot at a
// time from the home slot, and the result then passes to the output register.
// One transaction at a time: the next is taken only once the result is out.
// The hash runs on one shared 16 by 42-bit multiplier; the probe loop is
// set by the single read port of the slot memory.
// Reset: synchronous, then a clearing pass over all SLOTS (1024) slots with
// s_tready low.
// ----------------------------------------------------------------------------
module linear_probe_hash_table (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [lpht_pkg::S_TDATA_W-1:0]  s_tdata,   // key, payload_in
  input  logic                            s_tuser,   // operation
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [lpht_pkg::M_TDATA_W-1:0]  m_tdata    // found, payload_out, status, zero pad
);
  import lpht_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HASH  = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]          state;
  logic [SLOT_W-1:0]   clr_addr;
  logic                op;
  logic [KEY_W-1:0]    key;
  logic [PAY_W-1:0]    pay;
  logic [KEY_W-1:0]    key_sh;
  logic [HASH_W-1:0]   mult_sh;
  logic [HASH_W-1:0]   acc;
  logic [HASH_W-1:0]   acc_next;
  logic [HCNT_W-1:0]   hcnt;
  logic [SLOT_W-1:0]   place;
  logic [SLOT_W-1:0]   rd_addr;
  logic [COUNT_W-1:0]  entry_count;
  logic                res_found;
  logic [PAY_W-1:0]    res_pay;
  logic                res_status;
  logic                out_found;
  logic [PAY_W-1:0]    out_pay;
  logic                out_status;

  logic [HASH_W+CHUNK_W-1:0] prod;

  entry_t              mem [SLOTS];
  entry_t              rdata;
  entry_t              wdata;
  logic [SLOT_W-1:0]   waddr;
  logic                we;

  logic                hit;
  logic                empty;
  logic                room;
  logic                do_insert;

  // shared multiplier: one 16-bit key chunk per cycle
  assign prod     = key_sh[CHUNK_W-1:0] * mult_sh;
  assign acc_next = acc + prod[HASH_W-1:0];

  assign hit       = rdata.valid && (rdata.key == key);
  assign empty     = !rdata.valid;
  assign room      = entry_count < COUNT_W'(HALF_SLOTS);
  assign do_insert = (state == ST_CHECK) && empty && (op == OP_INSERT) && room;

  // next probe address: home slot at the end of the hash, else the following slot
  assign rd_addr = (state == ST_HASH) ? acc_next[32 +: SLOT_W] : place + 1'b1;

  assign we    = (state == ST_CLEAR) || do_insert;
  assign waddr = (state == ST_CLEAR) ? clr_addr : place;
  always_comb begin
    wdata         = '0;
    if (state != ST_CLEAR) begin
      wdata.valid   = 1'b1;
      wdata.key     = key;
      wdata.payload = pay;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
  end

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      entry_count <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == SLOT_W'(SLOTS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_HASH;
          end
        end
        ST_HASH: begin
          if (hcnt == HCNT_W'(HASH_CHUNKS - 1)) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (hit || empty) begin
            state <= ST_DONE;
          end
          if (do_insert) begin
            entry_count <= entry_count + 1'b1;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        op      <= s_tuser;
        key     <= s_tdata[KEY_W-1:0];
        pay     <= s_tdata[KEY_W +: PAY_W];
        key_sh  <= s_tdata[KEY_W-1:0];
        mult_sh <= HASH_MULT[HASH_W-1:0];
        acc     <= '0;
        hcnt    <= '0;
      end
      ST_HASH: begin
        acc     <= acc_next;
        key_sh  <= key_sh >> CHUNK_W;
        mult_sh <= mult_sh << CHUNK_W;
        hcnt    <= hcnt + 1'b1;
        place   <= rd_addr;
      end
      ST_CHECK: begin
        place      <= rd_addr;
        res_found  <= hit;
        res_pay    <= hit ? rdata.payload : '0;
        res_status <= !hit && (op == OP_INSERT) && !room;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_found  <= res_found;
          out_pay    <= res_pay;
          out_status <= res_status;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_tdata = {(M_TDATA_W - PAY_W - 2)'(0), out_status, out_pay, out_found};

  // load never passes one half
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= COUNT_W'(HALF_SLOTS))
    else $error("entry count above half load");

  // count only ever steps by one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (entry_count != $past(entry_count)) |-> (entry_count == $past(entry_count) + 1'b1))
    else $error("entry count jumped");

  // a refused insert never reports found
  a_status_found: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_found && out_status))
    else $error("found and refused together");

  // an insert into an empty slot always ends the probe
  a_insert_end: assert property (@(posedge clk) disable iff (rst)
    do_insert |=> (state == ST_DONE))
    else $error("insert without finishing the probe");

endmodule

FILE: tb/lpht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_checker
// Watches both stream channels of the hash table, keeps its own copy of the
// table contents, works out the reply for every accepted request and compares
// each returned reply, field by field, with the oldest one still awaited.
// ----------------------------------------------------------------------------
module lpht_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [lpht_pkg::S_TDATA_W-1:0]  s_tdata,   // key, payload_in
  input  logic                            s_tuser,   // operation
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [lpht_pkg::M_TDATA_W-1:0]  m_tdata,   // found, payload_out, status, zero pad
  output int                              mismatch_count,
  output int                              replies_due
);
  import lpht_pkg::*;

  typedef struct packed {
    logic             found;
    logic [PAY_W-1:0] payload;
    logic             status;
  } reply_t;

  logic             occupied   [SLOTS];
  logic [KEY_W-1:0] stored_key [SLOTS];
  logic [PAY_W-1:0] stored_pay [SLOTS];
  int               entry_total;
  reply_t           awaited_replies [$];

  initial begin
    mismatch_count = 0;
    replies_due    = 0;
  end

  // probe from the home slot to the key or the first empty slot, then update
  function automatic reply_t table_access(input logic op, input logic [KEY_W-1:0] k,
                                          input logic [PAY_W-1:0] p);
    reply_t            r;
    logic [63:0]       h;
    logic [SLOT_W-1:0] idx;
    int                n;
    logic              hit;
    r   = '0;
    h   = k * HASH_MULT;
    idx = h[32 +: SLOT_W];
    n   = 0;
    while (n < SLOTS && occupied[idx] && stored_key[idx] != k) begin
      idx = idx + 1'b1;
      n++;
    end
    hit = occupied[idx] && stored_key[idx] == k;
    if (hit) begin
      r.found   = 1'b1;
      r.payload = stored_pay[idx];
    end else if (op == OP_INSERT) begin
      if (n >= SLOTS || entry_total >= HALF_SLOTS) begin
        r.status = 1'b1;
      end else begin
        occupied[idx]   = 1'b1;
        stored_key[idx] = k;
        stored_pay[idx] = p;
        entry_total++;
      end
    end
    return r;
  endfunction

  task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= 60)
      $display("%0t ns: %s is %0h, expected %0h", $time, field, got, want);
  endtask

  always @(posedge clk) begin : watch
    reply_t got;
    reply_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) occupied[i] = 1'b0;
      entry_total = 0;
      awaited_replies.delete();
    end else begin
      if (s_tvalid && s_tready)
        awaited_replies.push_back(table_access(s_tuser, s_tdata[KEY_W-1:0],
                                               s_tdata[KEY_W +: PAY_W]));
      if (m_tvalid && m_tready) begin
        got.found   = m_tdata[0];
        got.payload = m_tdata[PAY_W:1];
        got.status  = m_tdata[PAY_W+1];
        if (awaited_replies.size() == 0) begin
          report("unrequested reply, m_tdata", 64'(m_tdata), 64'd0);
        end else begin
          want = awaited_replies.pop_front();
          if (got.found != want.found)
            report("found", 64'(got.found), 64'(want.found));
          if (got.payload != want.payload)
            report("payload_out", 64'(got.payload), 64'(want.payload));
          if (got.status != want.status)
            report("status", 64'(got.status), 64'(want.status));
        end
      end
    end
    replies_due <= awaited_replies.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives inserts and lookups into the linear probing hash table: a directed
// run over edge keys, duplicates and a probe chain that wraps at the last
// slot, then random traffic that fills the table up to half load so that new
// keys get refused. Sender gaps and receiver stalls change from phase to phase.
// ----------------------------------------------------------------------------
module testbench;
  import lpht_pkg::*;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata  = '0;
  logic                  s_tuser  = OP_INSERT;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  int                    mismatch_count;
  int                    replies_due;

  int gap_pct   = 0;
  int stall_pct = 0;

  logic [KEY_W-1:0] key_pool [$];

  linear_probe_hash_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  lpht_checker chk (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .mismatch_count (mismatch_count),
    .replies_due    (replies_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

  // home slot, used only to aim keys at a chosen stretch of the table
  function automatic int home_of(input logic [KEY_W-1:0] k);
    logic [63:0] h;
    h = k * HASH_MULT;
    return int'(h[32 +: SLOT_W]);
  endfunction

  // random key whose home slot falls in [lo, lo + span), wrapping
  function automatic logic [KEY_W-1:0] key_near(input int lo, input int span);
    logic [KEY_W-1:0] k;
    do k = {$urandom, $urandom}; while (((home_of(k) - lo) & (SLOTS - 1)) >= span);
    return k;
  endfunction

  // a quarter of new keys pile up around the wrap point to build long chains
  function automatic logic [KEY_W-1:0] fresh_key();
    if ($urandom_range(3) == 0) return key_near(SLOTS - 6, 8);
    return {$urandom, $urandom};
  endfunction

  function automatic logic [KEY_W-1:0] odd_key();
    if ($urandom_range(1)) return 64'd1 << $urandom_range(63);
    return 64'($urandom_range(15));
  endfunction

  task automatic send_item(input logic op, input logic [KEY_W-1:0] k,
                           input logic [PAY_W-1:0] p);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= S_TDATA_W'({p, k});
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic insert_key(input logic [KEY_W-1:0] k, input logic [PAY_W-1:0] p);
    key_pool.push_back(k);
    send_item(OP_INSERT, k, p);
  endtask

  // hold the sender until every reply has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (replies_due != 0);
  endtask

  initial begin
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] wrap_a;
    logic [KEY_W-1:0] wrap_b;
    logic [KEY_W-1:0] wrap_c;
    logic [PAY_W-1:0] p;
    logic             op;
    int               roll;
    int               gaps   [4];
    int               stalls [4];

    gaps   = '{0, 51, 0, 12};
    stalls = '{0, 0, 51, 12};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, edge keys and payloads, duplicates
    send_item(OP_LOOKUP, 64'd0, 32'hFFFF_FFFF);
    insert_key(64'd0, 32'd0);
    send_item(OP_LOOKUP, 64'd0, 32'd0);
    insert_key('1, 32'hFFFF_FFFF);
    send_item(OP_LOOKUP, '1, 32'h1234_5678);
    send_item(OP_INSERT, 64'd0, 32'h1234_5678);
    send_item(OP_INSERT, '1, 32'd0);
    send_item(OP_LOOKUP, 64'h8000_0000_0000_0000, 32'd0);
    insert_key(64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA);
    insert_key(64'h5555_5555_5555_5555, 32'h5555_5555);
    send_item(OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 32'd0);
    send_item(OP_LOOKUP, 64'h5555_5555_5555_5555, 32'd0);

    // three keys homed on the last slot: the chain wraps past key 0 in slot 0 to slots 1 and 2
    wrap_a = key_near(SLOTS - 1, 1);
    wrap_b = key_near(SLOTS - 1, 1);
    wrap_c = key_near(SLOTS - 1, 1);
    insert_key(wrap_a, 32'h0000_0001);
    insert_key(wrap_b, 32'h0000_0002);
    insert_key(wrap_c, 32'h0000_0003);
    send_item(OP_LOOKUP, wrap_c, 32'd0);
    send_item(OP_LOOKUP, wrap_a, 32'd0);
    send_item(OP_INSERT, wrap_b, 32'hDEAD_0000);
    send_item(OP_LOOKUP, key_near(SLOTS - 1, 1), 32'd0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      gap_pct   = gaps[ph];
      stall_pct = stalls[ph];
      for (int n = 0; n < 333; n++) begin
        roll = $urandom_range(99);
        p    = $urandom;
        if (roll < 50 || key_pool.size() == 0) begin
          insert_key(fresh_key(), p);
        end else if (roll < 60) begin
          send_item(OP_INSERT, key_pool[$urandom_range(key_pool.size() - 1)], p);
        end else if (roll < 82) begin
          send_item(OP_LOOKUP, key_pool[$urandom_range(key_pool.size() - 1)], p);
        end else if (roll < 92) begin
          send_item(OP_LOOKUP, fresh_key(), p);
        end else begin
          k  = odd_key();
          op = logic'($urandom_range(1));
          if (op == OP_INSERT) insert_key(k, p);
          else send_item(OP_LOOKUP, k, p);
        end
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && replies_due == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
